// File: hw/rtl/urm_pkg.sv
package urm_pkg;

	localparam int WAIT_W      = 12;
	localparam int TICK_W      = 7;
	localparam int CM_W        = 8;
	localparam int DIST_W      = 14;
	localparam int SEG_W       = 7;
	localparam int BCD_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;

	localparam int COUNT_BITS_DEF = 12;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [DIST_W-1:0] MAX_DISTANCE = 14'd9999;

	// register reset values
	localparam logic [WAIT_W-1:0] TRIGGER_TICKS_RST = 12'd100;
	localparam logic [WAIT_W-1:0] HOLDOFF_TICKS_RST = 12'd100;
	localparam logic [TICK_W-1:0] TICK_US_RST       = 7'd10;
	localparam logic [CM_W-1:0]   US_PER_CM_RST     = 8'd58;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_US       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM     = 3'd3;

	localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	typedef struct packed {
		logic trig;
		logic done;
	} urm_tag_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
		logic [SEG_W-1:0] pat;
		pat = '0;
		if (digit <= 4'd9) begin
			pat = SEG_TABLE[digit];
		end
		return pat;
	endfunction

endpackage

// File: hw/rtl/urm_ifs.sv
interface urm_in_if;
	logic valid;
	logic ready;
	logic echo;

	modport source (output valid, output echo, input ready);
	modport sink   (input valid, input echo, output ready);
endinterface

interface urm_out_if;
	logic                       valid;
	logic                       ready;
	logic                       trigger;
	logic                       done_res;
	logic [urm_pkg::DIST_W-1:0] distance_cm;
	logic [urm_pkg::SEG_W-1:0]  seg_units;
	logic [urm_pkg::SEG_W-1:0]  seg_tens;
	logic [urm_pkg::SEG_W-1:0]  seg_hundreds;
	logic [urm_pkg::SEG_W-1:0]  seg_thousands;

	modport source (output valid, output trigger, output done_res, output distance_cm,
		output seg_units, output seg_tens, output seg_hundreds, output seg_thousands,
		input ready);
	modport sink (input valid, input trigger, input done_res, input distance_cm,
		input seg_units, input seg_tens, input seg_hundreds, input seg_thousands,
		output ready);
endinterface

interface urm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [urm_pkg::CFG_IDX_W-1:0]  index;
	logic [urm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/urm_queue.sv
module urm_queue import urm_pkg::*; #(
	parameter int WIDTH = 2 + COUNT_BITS_DEF,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data,
	input  logic             pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = p + 1'b1;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end
		return r;
	endfunction

	assign full       = (fill_q == CNT_W'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/urm_front.sv
module urm_front import urm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	urm_in_if.sink                sample,
	input  logic [WAIT_W-1:0]     trigger_ticks,
	input  logic [WAIT_W-1:0]     holdoff_ticks,
	input  logic                  q_full,
	output logic                  q_push,
	output urm_tag_t              q_tag,
	output logic [COUNT_BITS-1:0] q_count
);

	localparam logic [1:0] PH_TRIG = 2'd0;
	localparam logic [1:0] PH_ECHO = 2'd1;
	localparam logic [1:0] PH_HOLD = 2'd2;

	logic [1:0]            phase_q, phase_n;
	logic [WAIT_W-1:0]     wait_q, wait_n, wait_inc;
	logic [COUNT_BITS-1:0] ticks_q, ticks_n;
	logic                  seen_q, seen_n;
	logic                  accept;

	assign sample.ready = !q_full;
	assign accept       = sample.valid && !q_full;
	assign wait_inc     = wait_q + 1'b1;

	always_comb begin
		phase_n    = phase_q;
		wait_n     = wait_q;
		ticks_n    = ticks_q;
		seen_n     = seen_q;
		q_tag.trig = 1'b0;
		q_tag.done = 1'b0;
		unique case (phase_q)
			PH_ECHO: begin
				if (sample.echo) begin
					seen_n = 1'b1;
					if (ticks_q != '1) begin
						ticks_n = ticks_q + 1'b1;
					end
				end else if (seen_q) begin
					q_tag.done = 1'b1;
					seen_n     = 1'b0;
					wait_n     = '0;
					phase_n    = (holdoff_ticks == '0) ? PH_TRIG : PH_HOLD;
				end
			end
			PH_HOLD: begin
				wait_n = wait_inc;
				if (wait_inc >= holdoff_ticks) begin
					wait_n  = '0;
					phase_n = PH_TRIG;
				end
			end
			default: begin
				// unused code falls back to the trigger phase
				q_tag.trig = 1'b1;
				phase_n    = PH_TRIG;
				wait_n     = wait_inc;
				if (wait_inc >= trigger_ticks) begin
					wait_n  = '0;
					ticks_n = '0;
					seen_n  = 1'b0;
					phase_n = PH_ECHO;
				end
			end
		endcase
	end

	assign q_push  = accept;
	assign q_count = ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRIG;
			wait_q  <= '0;
			ticks_q <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			wait_q  <= wait_n;
			ticks_q <= ticks_n;
			seen_q  <= seen_n;
		end
	end

endmodule

// File: hw/rtl/urm_back.sv
module urm_back import urm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  urm_tag_t              q_tag,
	input  logic [COUNT_BITS-1:0] q_count,
	output logic                  q_pop,
	input  logic [TICK_W-1:0]     tick_us,
	input  logic [CM_W-1:0]       us_per_cm,
	urm_out_if.source             result
);

	localparam int PROD_W = COUNT_BITS + TICK_W;
	localparam int CNT_W  = $clog2(PROD_W);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_BCD  = 2'd2;
	localparam logic [1:0] B_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] quo_q, quo_n;
	logic [CM_W-1:0]   rem_q, rem_n;
	logic [CM_W:0]     rem_sh;
	logic              rem_ge;
	logic              trig_q;
	logic [DIST_W-1:0] dist_sat;
	logic [DIST_W-1:0] dist_new_q;
	logic [DIST_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_w_q, bcd_adj, bcd_n;
	logic [DIST_W-1:0] dist_q;
	logic [BCD_W-1:0]  dig_q;
	logic              out_free;
	logic              out_load;

	// restoring divide, one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[PROD_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, us_per_cm});
	assign rem_n  = rem_ge ? CM_W'(rem_sh - {1'b0, us_per_cm}) : rem_sh[CM_W-1:0];
	assign quo_n  = {quo_q[PROD_W-2:0], rem_ge};

	assign dist_sat = ((us_per_cm == '0) || (quo_n > PROD_W'(MAX_DISTANCE)))
		? MAX_DISTANCE : quo_n[DIST_W-1:0];

	// shift-add-3 decimal split, one bit a cycle
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			bcd_adj[4*k +: 4] = (bcd_w_q[4*k +: 4] >= 4'd5)
				? bcd_w_q[4*k +: 4] + 4'd3 : bcd_w_q[4*k +: 4];
		end
		bcd_n = {bcd_adj[BCD_W-2:0], bin_q[DIST_W-1]};
	end

	assign out_free = !result.valid || result.ready;
	assign q_pop    = (state_q == B_IDLE) && q_valid && (q_tag.done || out_free);
	assign out_load = (q_pop && !q_tag.done) || (state_q == B_EMIT && out_free);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (q_pop && q_tag.done) begin
					quo_q  <= PROD_W'(q_count) * PROD_W'(tick_us);
					rem_q  <= '0;
					trig_q <= q_tag.trig;
				end
			end
			B_DIV: begin
				quo_q <= quo_n;
				rem_q <= rem_n;
				if (cnt_q == '0) begin
					dist_new_q <= dist_sat;
					bin_q      <= dist_sat;
					bcd_w_q    <= '0;
				end
			end
			B_BCD: begin
				bcd_w_q <= bcd_n;
				bin_q   <= bin_q << 1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			cnt_q         <= '0;
			dist_q        <= '0;
			dig_q         <= '0;
			result.valid  <= 1'b0;
		end else begin
			// load a new beat, or drop the one the receiver took
			if (out_load) begin
				result.valid <= 1'b1;
			end else if (result.ready) begin
				result.valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_pop && q_tag.done) begin
						cnt_q   <= CNT_W'(PROD_W - 1);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(DIST_W - 1);
						state_q <= B_BCD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				B_BCD: begin
					if (cnt_q == '0) begin
						dist_q  <= dist_new_q;
						dig_q   <= bcd_n;
						state_q <= B_EMIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
			endcase
		end
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			result.trigger       <= (state_q == B_EMIT) ? trig_q : q_tag.trig;
			result.done_res      <= (state_q == B_EMIT);
			result.distance_cm   <= dist_q;
			result.seg_units     <= seg_of(dig_q[3:0]);
			result.seg_tens      <= seg_of(dig_q[7:4]);
			result.seg_hundreds  <= seg_of(dig_q[11:8]);
			result.seg_thousands <= seg_of(dig_q[15:12]);
		end
	end

endmodule

// File: hw/rtl/ultrasonic_range_meter.sv
// Ultrasonic range meter with 7-segment digit output.
//
// sample: one beat per time tick, carrying the sampled echo line level.
// result: one beat per sample beat, in order: trigger level to drive,
//   done_res on the tick a new distance was computed, the last distance in
//   cm (saturated to 9999) and its four digits as segments (bit0 = a).
// cfg: register writes (0 trigger_ticks, 1 holdoff_ticks, 2 tick_us,
//   3 us_per_cm); other indexes are dropped. Always ready. Write only idle.
//
// Path: a result passes through the queue and the output register behind
// its sample beat. Ordinary ticks stream at one per cycle while the
// result receiver keeps up and no measurement is being computed. The tick
// that ends an echo passes through the restoring divider, then the
// shift-add-3 digit split and the emit state; meanwhile the front keeps
// taking samples until the two-entry queue fills.
//
// Reset: trigger phase, counters and distance clear to zero, registers to
// their defaults. A stalled result receiver holds the output register; the
// queue then fills and sample.ready drops.
module ultrasonic_range_meter import urm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	urm_in_if.sink    sample,
	urm_out_if.source result,
	urm_cfg_if.sink   cfg
);

	localparam int QW = 2 + COUNT_BITS;

	logic [WAIT_W-1:0] trigger_ticks_q;
	logic [WAIT_W-1:0] holdoff_ticks_q;
	logic [TICK_W-1:0] tick_us_q;
	logic [CM_W-1:0]   us_per_cm_q;

	logic                  q_full;
	logic                  q_push;
	urm_tag_t              push_tag;
	logic [COUNT_BITS-1:0] push_count;
	logic                  q_valid;
	logic [QW-1:0]         head_data;
	urm_tag_t              head_tag;
	logic [COUNT_BITS-1:0] head_count;
	logic                  q_pop;

	// register file; writes are registered
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= TRIGGER_TICKS_RST;
			holdoff_ticks_q <= HOLDOFF_TICKS_RST;
			tick_us_q       <= TICK_US_RST;
			us_per_cm_q     <= US_PER_CM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TRIGGER_TICKS: trigger_ticks_q <= cfg.data[WAIT_W-1:0];
				CFG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg.data[WAIT_W-1:0];
				CFG_TICK_US:       tick_us_q       <= cfg.data[TICK_W-1:0];
				CFG_US_PER_CM:     us_per_cm_q     <= cfg.data[CM_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// front: phase sequencing per tick, classify each tick
	urm_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.trigger_ticks (trigger_ticks_q),
		.holdoff_ticks (holdoff_ticks_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_tag         (push_tag),
		.q_count       (push_count)
	);

	// queue decouples the tick sequencer from the divider
	urm_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({push_tag, push_count}),
		.full       (q_full),
		.head_valid (q_valid),
		.head_data  (head_data),
		.pop        (q_pop)
	);

	assign head_tag   = head_data[QW-1 -: 2];
	assign head_count = head_data[COUNT_BITS-1:0];

	// back: divide, saturate, decimal split, output register
	urm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_tag     (head_tag),
		.q_count   (head_count),
		.q_pop     (q_pop),
		.tick_us   (tick_us_q),
		.us_per_cm (us_per_cm_q),
		.result    (result)
	);

endmodule

// File: hw/rtl/urm_checker.sv
module urm_checker import urm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic              trigger,
	input logic              done_res,
	input logic [DIST_W-1:0] distance_cm,
	input logic [SEG_W-1:0]  seg_units,
	input logic [SEG_W-1:0]  seg_tens,
	input logic [SEG_W-1:0]  seg_hundreds,
	input logic [SEG_W-1:0]  seg_thousands
);

	// a measurement ends in the echo phase, never while triggering
	a_done_no_trig: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !trigger)
		else $error("done_res with trigger high");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> distance_cm <= MAX_DISTANCE)
		else $error("distance above saturation limit");

	a_zero_segs: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && distance_cm == '0 |-> seg_units == SEG_TABLE[0] &&
		seg_tens == SEG_TABLE[0] && seg_hundreds == SEG_TABLE[0] &&
		seg_thousands == SEG_TABLE[0])
		else $error("segments disagree with zero distance");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(distance_cm) &&
		$stable(done_res) && $stable(trigger))
		else $error("result beat changed while stalled");

endmodule

bind ultrasonic_range_meter urm_checker u_urm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.trigger       (result.trigger),
	.done_res      (result.done_res),
	.distance_cm   (result.distance_cm),
	.seg_units     (result.seg_units),
	.seg_tens      (result.seg_tens),
	.seg_hundreds  (result.seg_hundreds),
	.seg_thousands (result.seg_thousands)
);
